FILE: src/pid_controller_step_unit_defines.svh
// Assertion macros shared by the checker of the PID step unit.
// No dependencies; each macro expects clk and rst_n in the including scope.
`ifndef PID_CONTROLLER_STEP_UNIT_DEFINES_SVH
`define PID_CONTROLLER_STEP_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIDST_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PIDST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/pidst_pkg.sv
// Shared widths, constants, register indexes and stage types of the PID step unit.
// No dependencies.
package pidst_pkg;

    localparam int MEAS_W      = 16;
    localparam int GAIN_W      = 16;
    localparam int LIMIT_W     = 26;
    localparam int DRIVE_W     = 16;
    localparam int ERR_W       = MEAS_W + 1;
    localparam int PROD_W      = GAIN_W + ERR_W - 1;
    localparam int ISUM_W      = PROD_W + 1;
    localparam int PRE_W       = PROD_W + 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = LIMIT_W;
    localparam int SCALE_SHIFT = 10;

    localparam logic signed [GAIN_W-1:0]  GAIN_P_RST     = 16'sd8192;
    localparam logic signed [GAIN_W-1:0]  GAIN_I_RST     = 16'sd512;
    localparam logic signed [GAIN_W-1:0]  GAIN_D_RST     = 16'sd24576;
    localparam logic signed [MEAS_W-1:0]  SETPOINT_RST   = '0;
    localparam logic signed [LIMIT_W-1:0] LIMIT_LOW_RST  = -26'sd261120;
    localparam logic signed [LIMIT_W-1:0] LIMIT_HIGH_RST = 26'sd261120;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P      = 3'd0,
        REG_GAIN_I      = 3'd1,
        REG_GAIN_D      = 3'd2,
        REG_SETPOINT    = 3'd3,
        REG_LOOP_ENABLE = 3'd4,
        REG_LIMIT_LOW   = 3'd5,
        REG_LIMIT_HIGH  = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0]  gain_p;
        logic signed [GAIN_W-1:0]  gain_i;
        logic signed [GAIN_W-1:0]  gain_d;
        logic signed [MEAS_W-1:0]  setpoint;
        logic                      loop_enable;
        logic signed [LIMIT_W-1:0] limit_low;
        logic signed [LIMIT_W-1:0] limit_high;
    } cfg_t;

    typedef struct packed {
        logic                     en;
        logic signed [PROD_W-1:0] p_term;
        logic signed [PROD_W-1:0] i_term;
        logic signed [PROD_W-1:0] d_term;
    } prod_t;

endpackage

FILE: src/pidst_cfg_regs.sv
// Configuration register file of the PID step unit.
// Depends on pidst_pkg for the register indexes, reset values and cfg_t.
module pidst_cfg_regs
    import pidst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p      <= GAIN_P_RST;
            cfg_reg.gain_i      <= GAIN_I_RST;
            cfg_reg.gain_d      <= GAIN_D_RST;
            cfg_reg.setpoint    <= SETPOINT_RST;
            cfg_reg.loop_enable <= 1'b0;
            cfg_reg.limit_low   <= LIMIT_LOW_RST;
            cfg_reg.limit_high  <= LIMIT_HIGH_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_GAIN_P:      cfg_reg.gain_p      <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I:      cfg_reg.gain_i      <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D:      cfg_reg.gain_d      <= cfg_data[GAIN_W-1:0];
                REG_SETPOINT:    cfg_reg.setpoint    <= cfg_data[MEAS_W-1:0];
                REG_LOOP_ENABLE: cfg_reg.loop_enable <= cfg_data[0];
                REG_LIMIT_LOW:   cfg_reg.limit_low   <= cfg_data[LIMIT_W-1:0];
                REG_LIMIT_HIGH:  cfg_reg.limit_high  <= cfg_data[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/pidst_prod_stage.sv
// Input register and product stage: error, measurement step and the three gain products.
// Depends on pidst_pkg for widths, cfg_t and prod_t.
module pidst_prod_stage
    import pidst_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [MEAS_W-1:0] measurement,
    output logic                     prod_valid,
    input  logic                     prod_ready,
    output prod_t                    prod
);

    logic                     in_vld_reg;
    logic                     in_vld_next;
    logic signed [MEAS_W-1:0] meas_reg;
    logic                     en_reg;
    logic                     prod_vld_reg;
    logic                     prod_vld_next;
    prod_t                    prod_reg;
    prod_t                    prod_next;
    logic signed [MEAS_W-1:0] prev_meas_reg;
    logic signed [ERR_W-1:0]  err;
    logic signed [ERR_W-1:0]  dmeas;
    logic                     in_load;
    logic                     prod_take;
    logic                     prod_load;

    assign prod_take = !prod_vld_reg || prod_ready;
    assign in_ready  = !in_vld_reg || prod_take;
    assign in_load   = in_valid && in_ready;
    assign prod_load = in_vld_reg && prod_take;

    assign in_vld_next   = in_load || (in_vld_reg && !prod_take);
    assign prod_vld_next = prod_load || (prod_vld_reg && !prod_ready);

    always_comb
    begin
        err   = ERR_W'(cfg.setpoint) - ERR_W'(meas_reg);
        dmeas = ERR_W'(meas_reg) - ERR_W'(prev_meas_reg);
        prod_next.en     = en_reg;
        prod_next.p_term = PROD_W'(cfg.gain_p) * PROD_W'(err);
        prod_next.i_term = PROD_W'(cfg.gain_i) * PROD_W'(err);
        prod_next.d_term = PROD_W'(cfg.gain_d) * PROD_W'(dmeas);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg    <= 1'b0;
            prod_vld_reg  <= 1'b0;
            prev_meas_reg <= '0;
        end
        else
        begin
            in_vld_reg   <= in_vld_next;
            prod_vld_reg <= prod_vld_next;
            // A disabled transaction leaves the previous measurement untouched.
            if (prod_load && en_reg)
            begin
                prev_meas_reg <= meas_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            meas_reg <= measurement;
            en_reg   <= cfg.loop_enable;
        end
        if (prod_load)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod_valid = prod_vld_reg;
    assign prod      = prod_reg;

endmodule

FILE: src/pidst_sum_stage.sv
// Integrator with anti-windup clamp, output sum, clamp, descaling and result register.
// Depends on pidst_pkg for widths, the scale shift, cfg_t and prod_t.
module pidst_sum_stage
    import pidst_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      cfg,
    input  logic                      prod_valid,
    output logic                      prod_ready,
    input  prod_t                     prod,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [DRIVE_W-1:0] drive,
    output logic                      disabled
);

    localparam logic signed [LIMIT_W-1:0] ROUND_BIAS = LIMIT_W'((1 << SCALE_SHIFT) - 1);
    localparam logic signed [LIMIT_W-1:0] DRIVE_MAX  = LIMIT_W'((1 << (DRIVE_W - 1)) - 1);
    localparam logic signed [LIMIT_W-1:0] DRIVE_MIN  = -LIMIT_W'(1 << (DRIVE_W - 1));

    logic signed [LIMIT_W-1:0] integral_reg;
    logic signed [LIMIT_W-1:0] integral_next;
    logic                      res_vld_reg;
    logic                      res_vld_next;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic signed [DRIVE_W-1:0] drive_next;
    logic                      disabled_reg;
    logic signed [ISUM_W-1:0]  isum;
    logic signed [PRE_W-1:0]   pre;
    logic signed [LIMIT_W-1:0] pre_clamped;
    logic signed [LIMIT_W-1:0] biased;
    logic signed [LIMIT_W-1:0] descaled;
    logic                      load;

    // Upper limit first: inverted limits give limit_high above limit_high, else limit_low.
    function automatic logic signed [LIMIT_W-1:0] clamp_limits(
        input logic signed [PRE_W-1:0]   v,
        input logic signed [LIMIT_W-1:0] lo,
        input logic signed [LIMIT_W-1:0] hi
    );
        logic signed [LIMIT_W-1:0] r;
        if (v > PRE_W'(hi))
        begin
            r = hi;
        end
        else if (v < PRE_W'(lo))
        begin
            r = lo;
        end
        else
        begin
            r = v[LIMIT_W-1:0];
        end
        return r;
    endfunction

    assign prod_ready   = !res_vld_reg || out_ready;
    assign load         = prod_valid && prod_ready;
    assign res_vld_next = load || (res_vld_reg && !out_ready);

    always_comb
    begin
        isum          = ISUM_W'(integral_reg) + ISUM_W'(prod.i_term);
        integral_next = clamp_limits(PRE_W'(isum), cfg.limit_low, cfg.limit_high);
        pre           = PRE_W'(prod.p_term) + PRE_W'(integral_next) - PRE_W'(prod.d_term);
        pre_clamped   = clamp_limits(pre, cfg.limit_low, cfg.limit_high);
        // Adding the bias to negative values makes the arithmetic shift truncate toward zero.
        biased   = pre_clamped[LIMIT_W-1] ? pre_clamped + ROUND_BIAS : pre_clamped;
        descaled = biased >>> SCALE_SHIFT;
        if (!prod.en)
        begin
            drive_next = '0;
        end
        else if (descaled > DRIVE_MAX)
        begin
            drive_next = DRIVE_MAX[DRIVE_W-1:0];
        end
        else if (descaled < DRIVE_MIN)
        begin
            drive_next = DRIVE_MIN[DRIVE_W-1:0];
        end
        else
        begin
            drive_next = descaled[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg  <= 1'b0;
            integral_reg <= '0;
        end
        else
        begin
            res_vld_reg <= res_vld_next;
            if (load && prod.en)
            begin
                integral_reg <= integral_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            drive_reg    <= drive_next;
            disabled_reg <= !prod.en;
        end
    end

    assign out_valid = res_vld_reg;
    assign drive     = drive_reg;
    assign disabled  = disabled_reg;

endmodule

FILE: src/pid_controller_step_unit.sv
// PID step unit: derivative on measurement, integrator clamped to the output limits.
// Registers: input, product (three gain multipliers), then result, which drives out_valid.
// Throughput: one transaction per cycle unless out_ready stalls the output.
// Reset: rst_n clears the pipeline, the integrator and the previous measurement and
// loads the configuration registers with their defaults; the block is ready at once.
module pid_controller_step_unit
    import pidst_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [MEAS_W-1:0]  measurement,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [DRIVE_W-1:0] drive,
    output logic                      disabled
);

    cfg_t  cfg;
    prod_t prod;
    logic  prod_valid;
    logic  prod_ready;

    pidst_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pidst_prod_stage u_prod_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .measurement (measurement),
        .prod_valid  (prod_valid),
        .prod_ready  (prod_ready),
        .prod        (prod)
    );

    pidst_sum_stage u_sum_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod       (prod),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .drive      (drive),
        .disabled   (disabled)
    );

endmodule

FILE: src/pidst_checker.sv
// Port-level checker for the PID step unit, bound to the top level.
// Depends on pidst_pkg and on the assertion macros in pid_controller_step_unit_defines.svh.
`include "pid_controller_step_unit_defines.svh"

module pidst_checker
    import pidst_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [DRIVE_W-1:0] drive,
    input logic                      disabled
);

    logic [DRIVE_W:0] res_bits;

    assign res_bits = {drive, disabled};

    // A disabled result always carries a zero drive.
    `PIDST_ASSERT_SAME(a_disabled_zero, out_valid && disabled, drive == '0, "bad disabled drive")

    // The input side can only stall when a result is waiting and the pipeline is full.
    `PIDST_ASSERT_SAME(a_stall_source, !in_ready, out_valid && !out_ready, "unexplained stall")

    `PIDST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")

    `PIDST_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(res_bits), "result changed")

endmodule

bind pid_controller_step_unit pidst_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive),
    .disabled  (disabled)
);

FILE: tb/pid_controller_step_unit_tb.sv
// Self-checking testbench for the PID step unit: a directed table, then random traffic.
// Depends on pidst_pkg and pid_controller_step_unit; predictor or table checks each result.
module pid_controller_step_unit_tb;
    import pidst_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 311;
    localparam int DRAIN_CYCLES    = 4;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_IDX = 3'd7;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      disabled;
    } drive_result_t;

    typedef struct {
        logic                      is_write;
        logic [CFG_IDX_W-1:0]      idx;
        logic [CFG_DATA_W-1:0]     data;
        logic signed [MEAS_W-1:0]  meas;
        logic                      typed;
        drive_result_t             result;
    } directed_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic signed [MEAS_W-1:0]  measurement = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [DRIVE_W-1:0] drive;
    logic                      disabled;

    // Predictor state and its copy of the configuration registers.
    cfg_t                      loop_cfg;
    longint                    integral_acc;
    logic signed [MEAS_W-1:0]  last_meas;

    drive_result_t             pending_drives[$];
    directed_row_t             directed_rows[$];
    logic                      fixed_valid = 1'b0;
    drive_result_t             fixed_result;
    int                        src_idle_pct = 0;
    int                        sink_idle_pct = 0;
    logic                      wide_stimulus = 1'b0;
    int                        errors = 0;
    int                        results_checked = 0;
    int                        settings_count = 0;
    int                        stall_cycles = 0;

    pid_controller_step_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .measurement(measurement),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .drive      (drive),
        .disabled   (disabled)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic longint clamp_to_limits(longint v);
        // The upper limit is tested first, which matters when the limits are inverted.
        if (v > longint'($signed(loop_cfg.limit_high)))
            return longint'($signed(loop_cfg.limit_high));
        if (v < longint'($signed(loop_cfg.limit_low)))
            return longint'($signed(loop_cfg.limit_low));
        return v;
    endfunction

    function automatic drive_result_t predict_drive(logic signed [MEAS_W-1:0] meas);
        drive_result_t r;
        longint err;
        longint dmeas;
        longint pre;
        longint mag;
        r.drive    = '0;
        r.disabled = 1'b1;
        if (!loop_cfg.loop_enable)
            return r;
        err   = longint'($signed(loop_cfg.setpoint)) - longint'(meas);
        dmeas = longint'(meas) - longint'(last_meas);
        last_meas = meas;
        integral_acc = clamp_to_limits(integral_acc + longint'($signed(loop_cfg.gain_i)) * err);
        pre = err * longint'($signed(loop_cfg.gain_p)) + integral_acc
              - dmeas * longint'($signed(loop_cfg.gain_d));
        pre = clamp_to_limits(pre);
        // Divide by the scale, truncating toward zero, then saturate to the drive width.
        if (pre < 0)
            mag = -((-pre) >>> SCALE_SHIFT);
        else
            mag = pre >>> SCALE_SHIFT;
        if (mag > 32767)
            mag = 32767;
        if (mag < -32768)
            mag = -32768;
        r.drive    = DRIVE_W'(mag);
        r.disabled = 1'b0;
        return r;
    endfunction

    function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_GAIN_P:      loop_cfg.gain_p      = data[GAIN_W-1:0];
            REG_GAIN_I:      loop_cfg.gain_i      = data[GAIN_W-1:0];
            REG_GAIN_D:      loop_cfg.gain_d      = data[GAIN_W-1:0];
            REG_SETPOINT:    loop_cfg.setpoint    = data[MEAS_W-1:0];
            REG_LOOP_ENABLE: loop_cfg.loop_enable = data[0];
            REG_LIMIT_LOW:   loop_cfg.limit_low   = data[LIMIT_W-1:0];
            REG_LIMIT_HIGH:  loop_cfg.limit_high  = data[LIMIT_W-1:0];
            default: ;
        endcase
    endfunction

    // Monitor: register writes, input transactions and result checks, all at the rising edge.
    always @(posedge clk)
    begin
        drive_result_t got;
        drive_result_t want;
        if (rst_n)
        begin
            if (cfg_wr_en)
                apply_reg_write(cfg_index, cfg_data);
            if (out_valid && out_ready)
            begin
                got.drive    = drive;
                got.disabled = disabled;
                if (pending_drives.size() == 0)
                begin
                    $display("%0t: unexpected result drive=%0d disabled=%0b",
                             $realtime, got.drive, got.disabled);
                    errors++;
                end
                else
                begin
                    want = pending_drives.pop_front();
                    results_checked++;
                    if (got.drive !== want.drive)
                    begin
                        $display("%0t: drive mismatch, expected %0d, actual %0d",
                                 $realtime, want.drive, got.drive);
                        errors++;
                    end
                    if (got.disabled !== want.disabled)
                    begin
                        $display("%0t: disabled mismatch, expected %0b, actual %0b",
                                 $realtime, want.disabled, got.disabled);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                want = predict_drive(measurement);
                pending_drives.push_back(fixed_valid ? fixed_result : want);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $realtime, stall_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    task automatic send_measurement(logic signed [MEAS_W-1:0] m);
        if ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < src_idle_pct)
                @(negedge clk);
        end
        in_valid    <= 1'b1;
        measurement <= m;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Registers change only once every outstanding result has been checked.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        in_valid <= 1'b0;
        while (pending_drives.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        directed_row_t row;
        row = '{1'b1, idx, data, '0, 1'b0, '0};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_item(logic signed [MEAS_W-1:0] meas, logic typed,
                                     logic signed [DRIVE_W-1:0] drv, logic dis);
        directed_row_t row;
        row = '{1'b0, '0, '0, meas, typed, '{drv, dis}};
        directed_rows.push_back(row);
    endfunction

    // Unused upper bits of narrow registers carry random values; the block must drop them.
    function automatic logic [CFG_DATA_W-1:0] with_junk(logic [GAIN_W-1:0] v);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'($urandom);
        d[GAIN_W-1:0] = v;
        return d;
    endfunction

    task automatic randomize_settings();
        logic [CFG_DATA_W-1:0] en_data;
        int lo;
        int hi;
        int gain_span;
        wide_stimulus = ($urandom_range(3) == 0);
        gain_span = wide_stimulus ? 32767 : 3000;
        write_reg(REG_GAIN_P, with_junk(GAIN_W'(int'($urandom_range(2 * gain_span)) - gain_span)));
        write_reg(REG_GAIN_I, with_junk(GAIN_W'(int'($urandom_range(2 * gain_span)) - gain_span)));
        write_reg(REG_GAIN_D, with_junk(GAIN_W'(int'($urandom_range(2 * gain_span)) - gain_span)));
        write_reg(REG_SETPOINT, with_junk(GAIN_W'($urandom)));
        case ($urandom_range(7))
            0:
            begin
                lo = -33554432;
                hi = 33554431;
            end
            1:
            begin
                lo = int'($urandom_range(1 << 20));
                hi = -int'($urandom_range(1 << 20));
            end
            2:
            begin
                lo = int'($signed(LIMIT_W'($urandom)));
                hi = int'($signed(LIMIT_W'($urandom)));
            end
            default:
            begin
                lo = -int'($urandom_range(1 << 22));
                hi = int'($urandom_range(1 << 22));
            end
        endcase
        write_reg(REG_LIMIT_LOW, CFG_DATA_W'(lo));
        write_reg(REG_LIMIT_HIGH, CFG_DATA_W'(hi));
        en_data = CFG_DATA_W'($urandom);
        en_data[0] = ($urandom_range(7) != 0);
        write_reg(REG_LOOP_ENABLE, en_data);
        settings_count++;
    endtask

    function automatic logic signed [MEAS_W-1:0] random_measurement();
        int pick;
        int v;
        pick = $urandom_range(99);
        if (pick < 5)
            return pick[0] ? 16'sd32767 : -16'sd32768;
        if (wide_stimulus || pick < 25)
            return MEAS_W'($urandom);
        // Mostly small excursions around the target, as a running loop would see.
        v = int'($urandom_range(400)) - 200 + int'($signed(loop_cfg.setpoint));
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return MEAS_W'(v);
    endfunction

    initial
    begin
        int sent;
        int chunk;
        loop_cfg.gain_p      = GAIN_P_RST;
        loop_cfg.gain_i      = GAIN_I_RST;
        loop_cfg.gain_d      = GAIN_D_RST;
        loop_cfg.setpoint    = SETPOINT_RST;
        loop_cfg.loop_enable = 1'b0;
        loop_cfg.limit_low   = LIMIT_LOW_RST;
        loop_cfg.limit_high  = LIMIT_HIGH_RST;
        integral_acc = 0;
        last_meas    = '0;

        // Disabled after reset, then the reset gains driven hard into both limits.
        add_item(16'sd100, 1'b1, 16'sd0, 1'b1);
        add_item(-16'sd32768, 1'b1, 16'sd0, 1'b1);
        add_write(REG_LOOP_ENABLE, CFG_DATA_W'(1));
        add_item(16'sd0, 1'b1, 16'sd0, 1'b0);
        add_item(16'sd32767, 1'b1, -16'sd255, 1'b0);
        add_item(-16'sd32768, 1'b1, 16'sd255, 1'b0);
        add_item(16'sd32767, 1'b0, '0, 1'b0);
        // Widest limits reach both ends of the drive range.
        add_write(REG_LIMIT_LOW, CFG_DATA_W'(-33554432));
        add_write(REG_LIMIT_HIGH, CFG_DATA_W'(33554431));
        add_item(-16'sd32768, 1'b0, '0, 1'b0);
        add_item(16'sd32767, 1'b0, '0, 1'b0);
        // Extreme gains and setpoints give the largest error of either sign.
        add_write(REG_GAIN_P, CFG_DATA_W'(16'h8000));
        add_write(REG_GAIN_I, CFG_DATA_W'(16'h7fff));
        add_write(REG_GAIN_D, CFG_DATA_W'(16'h8000));
        add_write(REG_SETPOINT, CFG_DATA_W'(16'h7fff));
        add_item(-16'sd32768, 1'b0, '0, 1'b0);
        add_write(REG_SETPOINT, CFG_DATA_W'(16'h8000));
        add_item(16'sd32767, 1'b0, '0, 1'b0);
        // Inverted limits.
        add_write(REG_LIMIT_LOW, CFG_DATA_W'(1000));
        add_write(REG_LIMIT_HIGH, CFG_DATA_W'(-1000));
        add_item(16'sd0, 1'b0, '0, 1'b0);
        add_item(16'sd500, 1'b0, '0, 1'b0);
        // A write to the unused index must change nothing.
        add_write(REG_UNUSED_IDX, '1);
        add_item(16'sd7, 1'b0, '0, 1'b0);
        // Disabling freezes the state, re-enabling picks it up again.
        add_write(REG_LOOP_ENABLE, CFG_DATA_W'(0));
        add_item(16'sd1234, 1'b1, 16'sd0, 1'b1);
        add_write(REG_LOOP_ENABLE, CFG_DATA_W'(1));
        add_item(-16'sd1234, 1'b0, '0, 1'b0);

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        src_idle_pct  = 15;
        sink_idle_pct = 54;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_write)
            begin
                write_reg(directed_rows[i].idx, directed_rows[i].data);
            end
            else
            begin
                fixed_valid  = directed_rows[i].typed;
                fixed_result = directed_rows[i].result;
                send_measurement(directed_rows[i].meas);
                fixed_valid  = 1'b0;
            end
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct  = 15;
                    sink_idle_pct = 54;
                end
                1:
                begin
                    src_idle_pct  = 54;
                    sink_idle_pct = 15;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                randomize_settings();
                chunk = $urandom_range(20, 60);
                if (chunk > ITEMS_PER_PHASE - sent)
                    chunk = ITEMS_PER_PHASE - sent;
                repeat (chunk)
                begin
                    send_measurement(random_measurement());
                    sent++;
                end
            end
        end

        in_valid <= 1'b0;
        while (pending_drives.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("Checked %0d drive results across %0d random register settings,",
                 results_checked, settings_count);
        $display("under three sender and receiver stall profiles, with %0d errors.", errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
